### sv/pidht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pidht_pkg;

	// table geometry (slot count is a power of two, home slot is a mask of the key)
	localparam int TABLE_SLOTS = 64;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// result status codes
	localparam logic [2:0] ST_NEW       = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;

	typedef struct packed {
		logic [1:0]  op;
		logic [30:0] proc_key;
		logic [15:0] line_index;
		logic [5:0]  slot_select;
		logic [31:0] time_now;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot_out;
		logic [30:0] key_out;
		logic [15:0] index_out;
		logic [31:0] start_out;
	} rsp_t;

	// one stored record
	typedef struct packed {
		logic [30:0] key;
		logic [15:0] index;
		logic [31:0] start;
	} rec_t;

endpackage

`default_nettype wire

### sv/pid_hash_table_linear_probe.sv
`timescale 1ns / 1ps
`default_nettype none

// Process record table with open addressing and linear probing. Each request beat carries
// an op: insert or update (key, line index, start time), lookup by key, or a direct read
// of one slot; every request yields exactly one response beat. The home slot is the key
// modulo TABLE_SLOTS and probing walks forward one slot at a time with wrap. Insert takes
// the first empty slot or updates the record with the same key, and reports table full
// after a complete sweep; lookup stops at an empty slot, a match or a full sweep. Records
// live in a single-port-read, single-port-write memory with a registered read port, and
// every probe costs one read: a direct read or a hit on the home slot takes one read,
// a full sweep TABLE_SLOTS reads. Only one request is in flight at a time; the next
// one is taken while the previous response still waits in the output register. Slot valid
// bits are flip-flops cleared by reset, so the table is empty right after reset with no
// clearing pass.
module pid_hash_table_linear_probe (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_stall,
	input  pidht_pkg::req_t   req,
	output logic              rsp_valid,
	input  wire               rsp_stall,
	output pidht_pkg::rsp_t   rsp
);

	// controller states
	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_PROBE = 1'b1;

	logic                             state_q;
	pidht_pkg::req_t                  item_q;
	logic [pidht_pkg::SLOT_W-1:0]     ptr_q;
	logic [pidht_pkg::SLOT_W-1:0]     count_q;
	logic [pidht_pkg::TABLE_SLOTS-1:0] valid_q;

	// record memory
	pidht_pkg::rec_t                  mem [pidht_pkg::TABLE_SLOTS];
	pidht_pkg::rec_t                  rd_q;
	logic [pidht_pkg::SLOT_W-1:0]     rd_addr;
	logic                             wr_en;
	pidht_pkg::rec_t                  wr_rec;

	logic                             rsp_valid_q;
	pidht_pkg::rsp_t                  rsp_q;
	pidht_pkg::rsp_t                  rsp_d;

	logic                             accept;
	logic                             out_free;
	logic                             done;
	logic                             fire;
	logic                             advance;
	logic                             slot_empty;
	logic                             key_eq;
	logic                             last;
	logic                             sel_in_range;
	logic [pidht_pkg::SLOT_W-1:0]     ptr_next;
	logic [pidht_pkg::SLOT_W-1:0]     home;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign home     = pidht_pkg::SLOT_W'(req.proc_key % pidht_pkg::TABLE_SLOTS);
	assign ptr_next = (ptr_q == pidht_pkg::SLOT_W'(pidht_pkg::TABLE_SLOTS - 1)) ?
		'0 : ptr_q + 1'b1;

	// the slot under test is ptr_q, its record sits in rd_q
	assign slot_empty   = !valid_q[ptr_q];
	assign key_eq       = (rd_q.key == item_q.proc_key);
	assign last         = (count_q == pidht_pkg::SLOT_W'(pidht_pkg::TABLE_SLOTS - 1));
	assign sel_in_range = (32'(item_q.slot_select) < pidht_pkg::TABLE_SLOTS);

	// probe decision and response build
	always_comb begin
		done   = 1'b1;
		wr_en  = 1'b0;
		wr_rec = rd_q;
		rsp_d  = '0;
		rsp_d.status = pidht_pkg::ST_NOT_FOUND;
		case (item_q.op)
			pidht_pkg::OP_INSERT: begin
				if (slot_empty) begin
					wr_en            = 1'b1;
					wr_rec.key       = item_q.proc_key;
					wr_rec.index     = item_q.line_index;
					wr_rec.start     = item_q.time_now;
					rsp_d.status     = pidht_pkg::ST_NEW;
					rsp_d.slot_out   = 6'(ptr_q);
					rsp_d.key_out    = item_q.proc_key;
					rsp_d.index_out  = item_q.line_index;
					rsp_d.start_out  = item_q.time_now;
				end else if (key_eq) begin
					wr_en            = 1'b1;
					wr_rec.index     = item_q.line_index;
					wr_rec.start     = item_q.time_now;
					rsp_d.status     = pidht_pkg::ST_UPDATED;
					rsp_d.slot_out   = 6'(ptr_q);
					rsp_d.key_out    = rd_q.key;
					rsp_d.index_out  = item_q.line_index;
					rsp_d.start_out  = item_q.time_now;
				end else if (last) begin
					rsp_d.status     = pidht_pkg::ST_FULL;
				end else begin
					done             = 1'b0;
				end
			end
			pidht_pkg::OP_LOOKUP: begin
				if (slot_empty || last) begin
					if (!slot_empty && key_eq) begin
						rsp_d.status    = pidht_pkg::ST_FOUND;
						rsp_d.slot_out  = 6'(ptr_q);
						rsp_d.key_out   = rd_q.key;
						rsp_d.index_out = rd_q.index;
						rsp_d.start_out = rd_q.start;
					end
				end else if (key_eq) begin
					rsp_d.status    = pidht_pkg::ST_FOUND;
					rsp_d.slot_out  = 6'(ptr_q);
					rsp_d.key_out   = rd_q.key;
					rsp_d.index_out = rd_q.index;
					rsp_d.start_out = rd_q.start;
				end else begin
					done            = 1'b0;
				end
			end
			pidht_pkg::OP_READ: begin
				rsp_d.slot_out = item_q.slot_select;
				if (sel_in_range && !slot_empty) begin
					rsp_d.status    = pidht_pkg::ST_FOUND;
					rsp_d.key_out   = rd_q.key;
					rsp_d.index_out = rd_q.index;
					rsp_d.start_out = rd_q.start;
				end else begin
					rsp_d.status    = pidht_pkg::ST_EMPTY;
				end
			end
			default: begin
				rsp_d.status = pidht_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	assign fire    = (state_q == ST_PROBE) && done && out_free;
	assign advance = (state_q == ST_PROBE) && !done;

	// next read address: home or selected slot on accept, next slot while probing,
	// same slot while a finished result waits for the output register
	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = (req.op == pidht_pkg::OP_READ) ?
					pidht_pkg::SLOT_W'(req.slot_select) : home;
			end
			ST_PROBE: begin
				rd_addr = advance ? ptr_next : ptr_q;
			end
			default: begin
				rd_addr = ptr_q;
			end
		endcase
	end

	// record memory, read-first, writes only on the final probe of an insert
	always_ff @(posedge clk) begin
		if (fire && wr_en) begin
			mem[ptr_q] <= wr_rec;
		end
		rd_q <= mem[rd_addr];
	end

	// probe pointer tracks the slot whose record lands in rd_q
	always_ff @(posedge clk) begin
		ptr_q <= rd_addr;
		if (accept) begin
			item_q  <= req;
			count_q <= '0;
		end else if (advance) begin
			count_q <= count_q + 1'b1;
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fire && wr_en) begin
				valid_q[ptr_q] <= 1'b1;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	// a write only lands in an empty slot or over the record with the same key
	a_write_target: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && wr_en) |-> (!valid_q[ptr_q] || rd_q.key == item_q.proc_key))
		else $error("insert overwrote a foreign record");

	// a committed insert leaves its slot marked valid
	a_valid_set: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && wr_en) |=> valid_q[$past(ptr_q)])
		else $error("slot not valid after insert");

	// finishing a request hands a beat to the output and frees the controller
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (rsp_valid && state_q == ST_IDLE))
		else $error("finished request lost");
`endif

endmodule

`default_nettype wire
